[rtl/ihse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihse_pkg
// Types and constants for the image header size extractor: stream payloads,
// JPEG scan phases, format codes and marker values.
// ----------------------------------------------------------------------------
package ihse_pkg;

  // format codes
  localparam logic [1:0] FMT_NONE = 2'd0;
  localparam logic [1:0] FMT_PNG  = 2'd1;
  localparam logic [1:0] FMT_JPEG = 2'd2;

  // marker and magic bytes
  localparam logic [7:0] PNG_MAGIC_0 = 8'd137;
  localparam logic [7:0] PNG_MAGIC_1 = 8'h50;
  localparam logic [7:0] PNG_MAGIC_2 = 8'h4E;
  localparam logic [7:0] PNG_MAGIC_3 = 8'h47;
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_EOI    = 8'hD9;
  localparam logic [7:0] MARK_RST0   = 8'hD0;
  localparam logic [7:0] MARK_RST7   = 8'hD7;
  localparam logic [7:0] MARK_DHT    = 8'hC4;
  localparam logic [7:0] MARK_JPG    = 8'hC8;
  localparam logic [7:0] MARK_DAC    = 8'hCC;
  localparam logic [3:0] SOF_NIBBLE  = 4'hC;

  // byte positions of the PNG header fields, and where counting stops
  localparam logic [4:0] POS_PNG_MIN   = 5'd7;
  localparam logic [4:0] POS_JPEG_MIN  = 5'd2;
  localparam logic [4:0] POS_WIDTH_LO  = 5'd16;
  localparam logic [4:0] POS_HEIGHT_LO = 5'd20;
  localparam logic [4:0] POS_HDR_END   = 5'd23;
  localparam logic [4:0] POS_SAT       = 5'd24;

  // jpeg marker scan phases
  typedef enum logic [3:0] {
    PH_S0   = 4'd0,
    PH_S1   = 4'd1,
    PH_SCAN = 4'd2,
    PH_MARK = 4'd3,
    PH_LHI  = 4'd4,
    PH_LLO  = 4'd5,
    PH_SKIP = 4'd6,
    PH_F2   = 4'd7,
    PH_F3   = 4'd8,
    PH_F4   = 4'd9,
    PH_H1   = 4'd10,
    PH_H0   = 4'd11,
    PH_W1   = 4'd12,
    PH_W0   = 4'd13,
    PH_TAIL = 4'd14,
    PH_DONE = 4'd15
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  image_format;
    logic        size_found;
    logic [31:0] frame_width;
    logic [31:0] frame_height;
  } size_item_t;

  // expected PNG signature byte at positions 0..3
  function automatic logic [7:0] png_magic(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = PNG_MAGIC_0;
      2'd1:    m = PNG_MAGIC_1;
      2'd2:    m = PNG_MAGIC_2;
      default: m = PNG_MAGIC_3;
    endcase
    return m;
  endfunction

  // expected JPEG start bytes at positions 0..2
  function automatic logic [7:0] jpg_magic(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd1:    m = MARK_SOI;
      default: m = MARK_PREFIX;
    endcase
    return m;
  endfunction

endpackage

[rtl/image_header_size_extractor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_header_size_extractor
// Classifies a byte stream as PNG, JPEG or neither and pulls the picture
// dimensions from the PNG IHDR chunk or the first JPEG SOFn segment.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle on the byte channel, with last_byte
// set on the final byte of a file, and returns exactly one size transaction
// per file, registered in the cycle after the last byte is accepted. Every byte
// is handled by a single registered state update, so unstalled files stream at
// one byte per clock with no gaps between them. The byte channel stalls only
// when a final byte arrives while the previous file's result is still held
// stalled in the output register; all other bytes are taken regardless of the
// output side. All scan state returns to its reset value after each final
// byte. Sizes are 32-bit for PNG and 16-bit (zero-extended) for JPEG; a JPEG
// size counts only if at least one byte follows the SOF width field.
module image_header_size_extractor
  import ihse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_data,
  output logic       size_valid,
  input  logic       size_stall,
  output size_item_t size_data
);

  // scan state
  logic [4:0]   byte_position, byte_position_next;
  logic [1:0]   format_seen, format_seen_next;
  parse_phase_t parse_phase, parse_phase_next;
  logic [15:0]  skip_remaining, skip_remaining_next;
  logic [7:0]   length_upper, length_upper_next;
  logic [31:0]  width_held, width_held_next;
  logic [31:0]  height_held, height_held_next;
  logic         size_done, size_done_next;

  logic         byte_accept;
  logic         size_accept;
  logic         png_ok, jpg_ok;
  logic [7:0]   b;
  logic [4:0]   pos;
  logic [15:0]  seg_len;
  logic [15:0]  skip_dec;
  size_item_t   result;

  // only a final byte needs room in the output register
  assign byte_stall  = size_valid && size_stall && byte_data.last_byte;
  assign byte_accept = byte_valid && !byte_stall;
  assign size_accept = size_valid && !size_stall;

  assign b        = byte_data.image_byte;
  assign pos      = byte_position;
  assign seg_len  = {length_upper, b};
  assign skip_dec = skip_remaining - 16'd1;

  // next scan state for the incoming byte
  always_comb begin
    format_seen_next    = format_seen;
    parse_phase_next    = parse_phase;
    skip_remaining_next = skip_remaining;
    length_upper_next   = length_upper;
    width_held_next     = width_held;
    height_held_next    = height_held;
    size_done_next      = size_done;

    // signature checks
    if (pos < 5'd4 && b != png_magic(pos[1:0])) begin
      format_seen_next[0] = 1'b1;
    end
    if (pos < 5'd3 && b != jpg_magic(pos[1:0])) begin
      format_seen_next[1] = 1'b1;
    end
    png_ok = !format_seen_next[0];
    jpg_ok = !format_seen_next[1];

    // png width and height words
    if (png_ok && pos >= POS_WIDTH_LO && pos <= POS_HDR_END) begin
      if (pos < POS_HEIGHT_LO) begin
        width_held_next = {width_held[23:0], b};
      end else begin
        height_held_next = {height_held[23:0], b};
      end
      if (pos == POS_HDR_END) begin
        size_done_next = 1'b1;
      end
    end

    // jpeg marker scan
    case (parse_phase)
      PH_S0:   parse_phase_next = PH_S1;
      PH_S1:   parse_phase_next = PH_SCAN;
      PH_SCAN: begin
        if (b == MARK_PREFIX) begin
          parse_phase_next = PH_MARK;
        end
      end
      PH_MARK: begin
        if (b[7:4] == SOF_NIBBLE && b != MARK_DHT && b != MARK_JPG && b != MARK_DAC) begin
          parse_phase_next = PH_F2;
        end else if (b inside {[MARK_RST0:MARK_RST7], MARK_SOI, MARK_EOI}) begin
          parse_phase_next = PH_SCAN;
        end else begin
          parse_phase_next = PH_LHI;
        end
      end
      PH_LHI: begin
        length_upper_next = b;
        parse_phase_next  = PH_LLO;
      end
      PH_LLO: begin
        // lengths below 2 count as an empty segment
        if (seg_len < 16'd2) begin
          skip_remaining_next = 16'd0;
        end else begin
          skip_remaining_next = seg_len - 16'd2;
        end
        parse_phase_next = (skip_remaining_next == 16'd0) ? PH_SCAN : PH_SKIP;
      end
      PH_SKIP: begin
        skip_remaining_next = skip_dec;
        if (skip_dec == 16'd0) begin
          parse_phase_next = PH_SCAN;
        end
      end
      PH_F2: parse_phase_next = PH_F3;
      PH_F3: parse_phase_next = PH_F4;
      PH_F4: parse_phase_next = PH_H1;
      PH_H1: begin
        if (jpg_ok) begin
          height_held_next = {16'd0, b, 8'd0};
        end
        parse_phase_next = PH_H0;
      end
      PH_H0: begin
        if (jpg_ok) begin
          height_held_next = height_held_next | {24'd0, b};
        end
        parse_phase_next = PH_W1;
      end
      PH_W1: begin
        if (jpg_ok) begin
          width_held_next = {16'd0, b, 8'd0};
        end
        parse_phase_next = PH_W0;
      end
      PH_W0: begin
        if (jpg_ok) begin
          width_held_next = width_held_next | {24'd0, b};
        end
        parse_phase_next = PH_TAIL;
      end
      PH_TAIL: begin
        if (jpg_ok) begin
          size_done_next = 1'b1;
        end
        parse_phase_next = PH_DONE;
      end
      default: parse_phase_next = PH_DONE;
    endcase

    byte_position_next = (pos < POS_SAT) ? pos + 5'd1 : pos;

    // result for a final byte
    if (png_ok && pos >= POS_PNG_MIN) begin
      result.image_format = FMT_PNG;
    end else if (jpg_ok && pos >= POS_JPEG_MIN) begin
      result.image_format = FMT_JPEG;
    end else begin
      result.image_format = FMT_NONE;
    end
    result.size_found   = (result.image_format != FMT_NONE) && size_done_next;
    result.frame_width  = result.size_found ? width_held_next : 32'd0;
    result.frame_height = result.size_found ? height_held_next : 32'd0;
  end

  // scan state registers, cleared after each final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= 5'd0;
      format_seen    <= 2'd0;
      parse_phase    <= PH_S0;
      skip_remaining <= 16'd0;
      length_upper   <= 8'd0;
      width_held     <= 32'd0;
      height_held    <= 32'd0;
      size_done      <= 1'b0;
    end else if (byte_accept) begin
      if (byte_data.last_byte) begin
        byte_position  <= 5'd0;
        format_seen    <= 2'd0;
        parse_phase    <= PH_S0;
        skip_remaining <= 16'd0;
        length_upper   <= 8'd0;
        width_held     <= 32'd0;
        height_held    <= 32'd0;
        size_done      <= 1'b0;
      end else begin
        byte_position  <= byte_position_next;
        format_seen    <= format_seen_next;
        parse_phase    <= parse_phase_next;
        skip_remaining <= skip_remaining_next;
        length_upper   <= length_upper_next;
        width_held     <= width_held_next;
        height_held    <= height_held_next;
        size_done      <= size_done_next;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      size_valid <= 1'b0;
    end else if (byte_accept && byte_data.last_byte) begin
      size_valid <= 1'b1;
    end else if (size_accept) begin
      size_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (byte_accept && byte_data.last_byte) begin
      size_data <= result;
    end
  end

  // a final byte returns the scan to its start
  assert property (@(posedge clk) disable iff (rst)
    byte_accept && byte_data.last_byte |=> byte_position == 5'd0 && parse_phase == PH_S0)
    else $error("scan state not cleared after final byte");

  // a result appears only after a final byte transaction
  assert property (@(posedge clk) disable iff (rst)
    $rose(size_valid) |-> $past(byte_accept && byte_data.last_byte))
    else $error("result without a final byte");

  // a reported size always comes with a known format
  assert property (@(posedge clk) disable iff (rst)
    size_valid && size_data.size_found |-> size_data.image_format != FMT_NONE)
    else $error("size reported for unknown format");

  // segment skipping never idles on an empty count
  assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_SKIP |-> skip_remaining != 16'd0)
    else $error("skip phase with nothing to skip");

  // the byte counter saturates
  assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_SAT)
    else $error("byte position past saturation");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams PNG, JPEG and junk files byte by byte into the image header size
// extractor and checks every size transaction against an in-bench tracker,
// or, for the short table of hand-built files that runs first, its table row;
// then random files run with random gaps on bytes and random stalls on sizes.
// ----------------------------------------------------------------------------
module testbench;
  import ihse_pkg::*;

  localparam int RANDOM_BYTES  = 1400;
  localparam int DIRECTED_ROWS = 30;

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       typed;
    size_item_t want;
  } stim_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  byte_item_t byte_data = '0;
  logic       size_valid;
  logic       size_stall = 1'b0;
  size_item_t size_data;

  image_header_size_extractor dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data (byte_data),
    .size_valid(size_valid),
    .size_stall(size_stall),
    .size_data (size_data)
  );

  // hand-built files: a lone byte, a JPEG with a short segment and the
  // largest size, a PNG too short for a size, a JPEG ending on a marker
  stim_row_t directed_table [DIRECTED_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, '{FMT_NONE, 1'b0, 32'd0, 32'd0}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hD8, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hE0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hC0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h11, 1'b0, 1'b0, '0},
    '{8'h08, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{FMT_JPEG, 1'b1, 32'h0000FFFF, 32'h0000FFFF}},
    '{8'd137, 1'b0, 1'b0, '0},
    '{8'h50, 1'b0, 1'b0, '0},
    '{8'h4E, 1'b0, 1'b0, '0},
    '{8'h47, 1'b0, 1'b0, '0},
    '{8'h0D, 1'b0, 1'b0, '0},
    '{8'h0A, 1'b0, 1'b0, '0},
    '{8'h1A, 1'b0, 1'b0, '0},
    '{8'h0A, 1'b1, 1'b1, '{FMT_PNG, 1'b0, 32'd0, 32'd0}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hD8, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hD9, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{FMT_JPEG, 1'b0, 32'd0, 32'd0}}
  };

  logic [7:0] png_sig  [4] = '{PNG_MAGIC_0, PNG_MAGIC_1, PNG_MAGIC_2, PNG_MAGIC_3};
  logic [7:0] jpeg_sig [3] = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX};

  // tracker state for the file being streamed
  logic [4:0]   seen_count;
  logic         png_bad;
  logic         jpeg_bad;
  parse_phase_t scan_phase;
  logic [15:0]  skip_left;
  logic [7:0]   len_hi;
  logic [31:0]  w_acc;
  logic [31:0]  h_acc;
  logic         dims_ready;

  size_item_t   pending_sizes [$];
  logic [7:0]   file_q [$];
  logic         typed_pending = 1'b0;
  size_item_t   typed_value = '0;
  int           sender_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           error_count = 0;
  int           bytes_taken = 0;
  int           png_seen = 0;
  int           jpeg_seen = 0;
  int           other_seen = 0;
  int           sizes_seen = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic is_sof(input logic [7:0] m);
    return m[7:4] == SOF_NIBBLE && m != MARK_DHT && m != MARK_JPG && m != MARK_DAC;
  endfunction

  function automatic logic is_standalone(input logic [7:0] m);
    return m == MARK_SOI || m == MARK_EOI || (m >= MARK_RST0 && m <= MARK_RST7);
  endfunction

  // picture dimension with a bias toward zero and all ones
  function automatic logic [31:0] pick_dim();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(1, 4096);
      default: return $urandom;
    endcase
  endfunction

  task automatic clear_tracker();
    seen_count = '0;
    png_bad    = 1'b0;
    jpeg_bad   = 1'b0;
    scan_phase = PH_S0;
    skip_left  = '0;
    len_hi     = '0;
    w_acc      = '0;
    h_acc      = '0;
    dims_ready = 1'b0;
  endtask

  // advance the tracker by one accepted byte; queue the size on the last one
  task automatic track_byte(input byte_item_t item);
    logic [7:0]  b;
    logic [4:0]  pos;
    logic [15:0] seg;
    size_item_t  res;
    b   = item.image_byte;
    pos = seen_count;

    // signature checks
    if (pos < 5'd4 && b != png_sig[pos[1:0]]) png_bad = 1'b1;
    if (pos < 5'd3 && b != jpeg_sig[pos[1:0]]) jpeg_bad = 1'b1;

    // png header words
    if (!png_bad && pos >= POS_WIDTH_LO && pos <= POS_HDR_END) begin
      if (pos < POS_HEIGHT_LO) w_acc = {w_acc[23:0], b};
      else h_acc = {h_acc[23:0], b};
      if (pos == POS_HDR_END) dims_ready = 1'b1;
    end

    // jpeg marker walk
    case (scan_phase)
      PH_S0:   scan_phase = PH_S1;
      PH_S1:   scan_phase = PH_SCAN;
      PH_SCAN: if (b == MARK_PREFIX) scan_phase = PH_MARK;
      PH_MARK: begin
        if (is_sof(b)) scan_phase = PH_F2;
        else if (is_standalone(b)) scan_phase = PH_SCAN;
        else scan_phase = PH_LHI;
      end
      PH_LHI: begin
        len_hi     = b;
        scan_phase = PH_LLO;
      end
      PH_LLO: begin
        seg = {len_hi, b};
        if (seg < 16'd2) seg = 16'd2;
        skip_left  = seg - 16'd2;
        scan_phase = (skip_left == 16'd0) ? PH_SCAN : PH_SKIP;
      end
      PH_SKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) scan_phase = PH_SCAN;
      end
      PH_F2: scan_phase = PH_F3;
      PH_F3: scan_phase = PH_F4;
      PH_F4: scan_phase = PH_H1;
      PH_H1: begin
        if (!jpeg_bad) h_acc = {16'd0, b, 8'd0};
        scan_phase = PH_H0;
      end
      PH_H0: begin
        if (!jpeg_bad) h_acc = h_acc | {24'd0, b};
        scan_phase = PH_W1;
      end
      PH_W1: begin
        if (!jpeg_bad) w_acc = {16'd0, b, 8'd0};
        scan_phase = PH_W0;
      end
      PH_W0: begin
        if (!jpeg_bad) w_acc = w_acc | {24'd0, b};
        scan_phase = PH_TAIL;
      end
      PH_TAIL: begin
        if (!jpeg_bad) dims_ready = 1'b1;
        scan_phase = PH_DONE;
      end
      default: scan_phase = PH_DONE;
    endcase

    if (seen_count < POS_SAT) seen_count = seen_count + 5'd1;

    // final byte closes the file
    if (item.last_byte) begin
      res = '0;
      if (!png_bad && pos >= POS_PNG_MIN) res.image_format = FMT_PNG;
      else if (!jpeg_bad && pos >= POS_JPEG_MIN) res.image_format = FMT_JPEG;
      if (res.image_format != FMT_NONE && dims_ready) begin
        res.size_found   = 1'b1;
        res.frame_width  = w_acc;
        res.frame_height = h_acc;
      end
      pending_sizes.push_back(typed_pending ? typed_value : res);
      clear_tracker();
    end
  endtask

  // byte side: random gap, then hold the transaction until it is taken
  task automatic send_byte(input byte_item_t item);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= item;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  // build one random file into file_q
  task automatic make_file();
    int unsigned kind;
    int unsigned cut;
    int unsigned k;
    logic [15:0] seg_len;
    logic [31:0] w;
    logic [31:0] h;
    logic [7:0]  m;
    logic        past_end;
    file_q.delete();
    past_end = 1'b0;
    kind = $urandom_range(0, 9);
    w = pick_dim();
    h = pick_dim();
    if (kind < 4) begin
      // png: signature, rest of the header, ihdr size words, some trailer
      file_q = '{PNG_MAGIC_0, PNG_MAGIC_1, PNG_MAGIC_2, PNG_MAGIC_3};
      repeat (12) file_q.push_back(8'($urandom));
      for (int s = 24; s >= 0; s -= 8) file_q.push_back(w[s +: 8]);
      for (int s = 24; s >= 0; s -= 8) file_q.push_back(h[s +: 8]);
      repeat ($urandom_range(0, 6)) file_q.push_back(8'($urandom));
    end else if (kind < 8) begin
      // jpeg: a few markers, fillers and segments, then a frame header unless past_end
      file_q = '{MARK_PREFIX, MARK_SOI};
      repeat ($urandom_range(0, 3)) begin
        if (!past_end) begin
          case ($urandom_range(0, 3))
            0: begin
              k = $urandom_range(0, 9);
              m = (k < 8) ? 8'(MARK_RST0 + k) : ((k == 8) ? MARK_SOI : MARK_EOI);
              file_q.push_back(MARK_PREFIX);
              file_q.push_back(m);
            end
            1: begin
              // filler only once the jpeg signature is complete
              if (file_q.size() > 2)
                repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(0, 254)));
            end
            default: begin
              do m = 8'($urandom); while (is_sof(m) || is_standalone(m));
              case ($urandom_range(0, 7))
                0:       seg_len = 16'($urandom_range(0, 1));
                1:       seg_len = 16'($urandom_range(256, 65535));
                default: seg_len = 16'($urandom_range(2, 10));
              endcase
              file_q.push_back(MARK_PREFIX);
              file_q.push_back(m);
              file_q.push_back(seg_len[15:8]);
              file_q.push_back(seg_len[7:0]);
              if (seg_len > 16'd64) begin
                // the file ends inside this segment
                repeat ($urandom_range(0, 5)) file_q.push_back(8'($urandom));
                past_end = 1'b1;
              end else begin
                repeat ((seg_len > 16'd2) ? seg_len - 16'd2 : 0)
                  file_q.push_back(8'($urandom));
              end
            end
          endcase
        end
      end
      if (!past_end) begin
        do m = {SOF_NIBBLE, 4'($urandom)}; while (m == MARK_DHT || m == MARK_JPG || m == MARK_DAC);
        file_q.push_back(MARK_PREFIX);
        file_q.push_back(m);
        repeat (3) file_q.push_back(8'($urandom));
        file_q.push_back(h[15:8]);
        file_q.push_back(h[7:0]);
        file_q.push_back(w[15:8]);
        file_q.push_back(w[7:0]);
        // no trailing byte leaves the size uncounted
        repeat ($urandom_range(0, 4)) file_q.push_back(8'($urandom));
      end
    end else begin
      // junk, sometimes with a partial signature in front
      case ($urandom_range(0, 2))
        0:       file_q = '{PNG_MAGIC_0, PNG_MAGIC_1, PNG_MAGIC_2};
        1:       file_q = '{MARK_PREFIX, MARK_SOI};
        default: ;
      endcase
      repeat ($urandom_range(1, 24)) file_q.push_back(8'($urandom));
    end

    // occasional truncation and a corrupted byte
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
    if ($urandom_range(0, 11) == 0)
      file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
  endtask

  // size side stalls at random
  always @(posedge clk) begin
    if (rst) begin
      size_stall <= 1'b0;
    end else begin
      size_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // track accepted bytes and check each size transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) begin
      track_byte(byte_data);
      bytes_taken++;
    end
    if (!rst && size_valid && !size_stall) begin
      if (pending_sizes.size() == 0) begin
        $display("%0t: unexpected size transaction fmt=%0d found=%0d w=%0d h=%0d", $time,
                 size_data.image_format, size_data.size_found, size_data.frame_width,
                 size_data.frame_height);
        error_count++;
      end else begin
        if (size_data !== pending_sizes[0]) begin
          $display("%0t: size mismatch expected fmt=%0d found=%0d w=%0d h=%0d", $time,
                   pending_sizes[0].image_format, pending_sizes[0].size_found,
                   pending_sizes[0].frame_width, pending_sizes[0].frame_height);
          $display("%0t:               actual fmt=%0d found=%0d w=%0d h=%0d", $time,
                   size_data.image_format, size_data.size_found, size_data.frame_width,
                   size_data.frame_height);
          error_count++;
        end
        void'(pending_sizes.pop_front());
      end
      case (size_data.image_format)
        FMT_PNG:  png_seen++;
        FMT_JPEG: jpeg_seen++;
        default:  other_seen++;
      endcase
      if (size_data.size_found) sizes_seen++;
    end
  end

  // stimulus
  initial begin
    int random_bytes;
    int random_files;
    random_bytes = 0;
    random_files = 0;
    clear_tracker();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    sender_idle_pct = 20;
    recv_idle_pct  <= 30;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      typed_pending <= directed_table[i].typed;
      typed_value   <= directed_table[i].want;
      send_byte('{image_byte: directed_table[i].b, last_byte: directed_table[i].last});
    end
    typed_pending <= 1'b0;

    // random files in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 35;
          recv_idle_pct  <= 56;
        end
        1: begin
          sender_idle_pct = 56;
          recv_idle_pct  <= 35;
        end
        default: begin
          sender_idle_pct = 0;
          recv_idle_pct  <= 0;
        end
      endcase
      while (random_bytes < (ph + 1) * RANDOM_BYTES / 3 || random_files < (ph + 1) * 15) begin
        make_file();
        for (int i = 0; i < file_q.size(); i++)
          send_byte('{image_byte: file_q[i], last_byte: (i == file_q.size() - 1)});
        random_bytes += file_q.size();
        random_files++;
      end
      // hold off until every size is back
      byte_valid <= 1'b0;
      @(posedge clk);
      while (pending_sizes.size() != 0) @(posedge clk);
    end

    // result is registered in the cycle after the last byte; leave room for strays
    repeat (10) @(posedge clk);
    $display("covered %0d bytes: %0d png, %0d jpeg, %0d other files, %0d with a size",
             bytes_taken, png_seen, jpeg_seen, other_seen, sizes_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("timeout with %0d sizes outstanding", pending_sizes.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
rtl/ihse_pkg.sv
rtl/image_header_size_extractor.sv
bench/testbench.sv
